// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is high.
`define WTR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define WTR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define WTR_ASSERT(label, clk, rst, prop, msg)
`define WTR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/wtr_pkg.sv =====
package wtr_pkg;

   localparam int WINDOW_DEPTH_DEF = 8;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 15;
   localparam int SPEED_W = 16;
   localparam int SCALE_W = 24;
   localparam int PROD_W  = SCALE_W + COUNT_W;   // 39
   localparam int CMP_W   = TIME_W + SPEED_W;    // 48
   localparam int DIV_STEPS = SPEED_W;
   localparam int STEP_W  = $clog2(DIV_STEPS);

   localparam logic [COUNT_W-1:0] COUNT_MODULUS = 15'd32767;
   localparam logic [SCALE_W-1:0] RPM_SCALE     = 24'd15000000;
   localparam logic [SPEED_W-1:0] RPM_MAX       = 16'hFFFF;

   typedef struct packed {
      logic [TIME_W-1:0]  timestamp_us;
      logic [COUNT_W-1:0] pulse_count;
   } wtr_req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_rpm;
      logic               zero_time_flag;
   } wtr_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]  sample_time;
      logic [COUNT_W-1:0] sample_count;
   } wtr_sample_type;

   // controller -> datapath
   typedef struct packed {
      logic take;        // input beat accepted: write ring, read oldest
      logic diff;        // count and time differences
      logic mul;         // scale product
      logic start_div;   // load divider
      logic step;        // one divider step
      logic load_out;    // fill output register
   } wtr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sat;         // zero elapsed time or quotient over range
   } wtr_status_type;

endpackage

// ===== hw/rtl/wtr_ring.sv =====
module wtr_ring #(
   parameter int DEPTH = wtr_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wtr_pkg::wtr_sample_type    wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output wtr_pkg::wtr_sample_type    rd_data,
   output logic                       rd_hit
);

   wtr_pkg::wtr_sample_type sample_mem_ff [DEPTH];
   wtr_pkg::wtr_sample_type rd_data_ff;
   logic [DEPTH-1:0]        valid_ff;
   logic                    rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sample_mem_ff[rd_addr];
      end
   end

   // entries never written read back with rd_hit low
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule

// ===== hw/rtl/wtr_datapath.sv =====
module wtr_datapath #(
   parameter int DEPTH = wtr_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wtr_pkg::wtr_cmd_type    cmd,
   input  wtr_pkg::wtr_req_type    req_data,
   output wtr_pkg::wtr_status_type status,
   output wtr_pkg::wtr_rsp_type    rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   logic [IDX_W-1:0] pos_ff, pos_in, rd_addr;

   wtr_pkg::wtr_sample_type new_sample, old_raw, old_sample;
   logic                    old_hit;

   logic [wtr_pkg::TIME_W-1:0]  now_ff;
   logic [wtr_pkg::COUNT_W-1:0] cnt_ff;
   logic [wtr_pkg::COUNT_W-1:0] revs_ff, revs_in;
   logic [wtr_pkg::TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [wtr_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [wtr_pkg::TIME_W-1:0]  rem_ff, rem_in;
   logic [wtr_pkg::SPEED_W-1:0] quot_ff, quot_in;
   wtr_pkg::wtr_rsp_type        rsp_ff, rsp_in;

   logic [wtr_pkg::COUNT_W:0]   sum0, sum1, sum2, modulus_ext;
   logic [wtr_pkg::TIME_W:0]    trial, trial_diff;
   logic                        trial_ge;
   logic                        zero_time, over_range;

   assign pos_in  = next_idx(pos_ff);
   assign rd_addr = next_idx(pos_in);

   assign new_sample.sample_time  = req_data.timestamp_us;
   assign new_sample.sample_count = req_data.pulse_count;

   wtr_ring #(
      .DEPTH(DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd.take),
      .wr_addr (pos_in),
      .wr_data (new_sample),
      .rd_en   (cmd.take),
      .rd_addr (rd_addr),
      .rd_data (old_raw),
      .rd_hit  (old_hit)
   );

   assign old_sample = old_hit ? old_raw : '0;

   // (32767 + new - oldest) mod 32767 with two conditional subtracts
   always_comb begin
      modulus_ext = {1'b0, wtr_pkg::COUNT_MODULUS};
      sum0 = modulus_ext + {1'b0, cnt_ff} - {1'b0, old_sample.sample_count};
      sum1 = (sum0 >= modulus_ext) ? sum0 - modulus_ext : sum0;
      sum2 = (sum1 >= modulus_ext) ? sum1 - modulus_ext : sum1;
      revs_in    = sum2[wtr_pkg::COUNT_W-1:0];
      elapsed_in = now_ff - old_sample.sample_time;
   end

   assign prod_in = wtr_pkg::PROD_W'(wtr_pkg::RPM_SCALE) * wtr_pkg::PROD_W'(revs_ff);

   // quotient fits 16 bits iff prod < elapsed * 2^16
   assign zero_time  = (elapsed_ff == '0);
   assign over_range = wtr_pkg::CMP_W'(prod_ff) >= {elapsed_ff, {wtr_pkg::SPEED_W{1'b0}}};
   assign status.sat = zero_time || over_range;

   // restoring divider step
   always_comb begin
      trial      = {rem_ff, quot_ff[wtr_pkg::SPEED_W-1]};
      trial_diff = trial - {1'b0, elapsed_ff};
      trial_ge   = (trial >= {1'b0, elapsed_ff});
      rem_in     = trial_ge ? trial_diff[wtr_pkg::TIME_W-1:0] : trial[wtr_pkg::TIME_W-1:0];
      quot_in    = {quot_ff[wtr_pkg::SPEED_W-2:0], trial_ge};
   end

   always_comb begin
      rsp_in.speed_rpm      = status.sat ? wtr_pkg::RPM_MAX : quot_ff;
      rsp_in.zero_time_flag = zero_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.take) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         now_ff <= req_data.timestamp_us;
         cnt_ff <= req_data.pulse_count;
      end
      if (cmd.diff) begin
         revs_ff    <= revs_in;
         elapsed_ff <= elapsed_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.start_div) begin
         rem_ff  <= wtr_pkg::TIME_W'(prod_ff[wtr_pkg::PROD_W-1:wtr_pkg::SPEED_W]);
         quot_ff <= prod_ff[wtr_pkg::SPEED_W-1:0];
      end else if (cmd.step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/wtr_control.sv =====
module wtr_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  wtr_pkg::wtr_status_type status,
   output wtr_pkg::wtr_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_CHK,
      S_DIV,
      S_DONE
   } state_type;

   state_type                   state_ff;
   logic [wtr_pkg::STEP_W-1:0]  step_ff;
   logic                        rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.take      = req_valid;
         S_READ: cmd.diff      = 1'b1;
         S_MUL:  cmd.mul       = 1'b1;
         S_CHK:  cmd.start_div = !status.sat;
         S_DIV:  cmd.step      = 1'b1;
         S_DONE: cmd.load_out  = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_MUL;
            S_MUL:  state_ff <= S_CHK;
            S_CHK: begin
               step_ff  <= '0;
               state_ff <= status.sat ? S_DONE : S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == wtr_pkg::STEP_W'(wtr_pkg::DIV_STEPS - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // wait here while the output register still holds an untaken beat
               if (cmd.load_out) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/windowed_tachometer_rpm_unit.sv =====
// channel  dir  beat             handshake
// req_     in   wtr_req_type     req_valid / req_ready
// rsp_     out  wtr_rsp_type     rsp_valid / rsp_ready
//
// The result enters the output register after ring read, difference,
// multiply, range check and a 16-step restoring divider; the next beat is
// taken once the unit is back in idle. Zero elapsed time or an over-range
// quotient skips the divider.
// Reset clears the ring valid bits at once; no clearing pass.
// A new beat is taken while a result waits on rsp_; a second result stalls
// in the final step until the output register is taken.
`include "assert_macros.svh"

module windowed_tachometer_rpm_unit #(
   parameter int WINDOW_DEPTH = wtr_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wtr_pkg::wtr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wtr_pkg::wtr_rsp_type rsp_data
);

   wtr_pkg::wtr_cmd_type    cmd;
   wtr_pkg::wtr_status_type status;

   wtr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wtr_datapath #(
      .DEPTH(WINDOW_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   `WTR_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "accepted beat did not make the unit busy")
   `WTR_ASSERT(a_zero_flag_saturates, clock, reset, (rsp_valid && rsp_data.zero_time_flag) |-> (rsp_data.speed_rpm == wtr_pkg::RPM_MAX), "zero time result not saturated")
   `WTR_ASSERT(a_result_from_busy, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "result appeared without an item in flight")

endmodule

// ===== tb/sv/tb_windowed_tachometer_rpm_unit.sv =====
module tb_windowed_tachometer_rpm_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMEOUT_CYCLES = 200_000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CALM_ITEMS     = 100;
   localparam int RANDOM_ITEMS   = 950;
   localparam int REPORT_LIMIT   = 10;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   wtr_pkg::wtr_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   wtr_pkg::wtr_rsp_type rsp_data;

   wtr_pkg::wtr_req_type pending_readings[$];
   wtr_pkg::wtr_rsp_type expected_speeds[$];

   // shadow of the window ring
   logic [wtr_pkg::TIME_W-1:0]  window_time  [wtr_pkg::WINDOW_DEPTH_DEF];
   logic [wtr_pkg::COUNT_W-1:0] window_count [wtr_pkg::WINDOW_DEPTH_DEF];
   int unsigned                 window_head = 0;

   int   send_gap        = 0;
   int   stall_left      = 0;
   int   phase_left      = 0;
   logic idle_on         = 1'b1;
   logic calm_tail       = 1'b0;
   int   cycle_count     = 0;
   int   readings_sent   = 0;
   int   speeds_checked  = 0;
   int   zero_time_seen  = 0;
   int   clipped_seen    = 0;
   int   fault_count     = 0;

   windowed_tachometer_rpm_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic wtr_pkg::wtr_rsp_type predict_speed(wtr_pkg::wtr_req_type reading);
      int unsigned                oldest;
      int unsigned                revs;
      logic [wtr_pkg::TIME_W-1:0] elapsed;
      logic [63:0]                quotient;
      wtr_pkg::wtr_rsp_type       speed;
      window_head = (window_head + 1) % wtr_pkg::WINDOW_DEPTH_DEF;
      window_time[window_head]  = reading.timestamp_us;
      window_count[window_head] = reading.pulse_count;
      oldest = (window_head + 1) % wtr_pkg::WINDOW_DEPTH_DEF;
      revs = (32'(wtr_pkg::COUNT_MODULUS) + reading.pulse_count - window_count[oldest])
             % wtr_pkg::COUNT_MODULUS;
      elapsed = reading.timestamp_us - window_time[oldest];
      speed.zero_time_flag = (elapsed == '0);
      if (speed.zero_time_flag) begin
         speed.speed_rpm = wtr_pkg::RPM_MAX;
      end else begin
         quotient = (64'(wtr_pkg::RPM_SCALE) * 64'(revs)) / 64'(elapsed);
         speed.speed_rpm = (quotient > 64'(wtr_pkg::RPM_MAX)) ?
                           wtr_pkg::RPM_MAX : quotient[wtr_pkg::SPEED_W-1:0];
      end
      return speed;
   endfunction

   function automatic void queue_reading(logic [wtr_pkg::TIME_W-1:0] stamp,
                                         logic [wtr_pkg::COUNT_W-1:0] pulses);
      wtr_pkg::wtr_req_type reading;
      reading.timestamp_us = stamp;
      reading.pulse_count  = pulses;
      pending_readings.push_back(reading);
   endfunction

   always @(posedge clock) begin : reading_driver
      logic holding;
      holding = req_valid;
      if (reset) begin
         holding = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_speeds.push_back(predict_speed(req_data));
            readings_sent++;
            holding = 1'b0;
            if (!calm_tail && idle_on && $urandom_range(0, 2) == 0)
               send_gap = $urandom_range(1, 4);
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_readings.size() > 0) begin
               req_data <= pending_readings.pop_front();
               holding = 1'b1;
            end
         end
         calm_tail <= (pending_readings.size() < CALM_ITEMS);
      end
      req_valid <= holding;
   end

   always @(posedge clock) begin : speed_monitor
      wtr_pkg::wtr_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_speeds.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: unexpected beat speed=%0d flag=%0b", $realtime,
                           rsp_data.speed_rpm, rsp_data.zero_time_flag);
            end else begin
               want = expected_speeds.pop_front();
               speeds_checked++;
               if (rsp_data.speed_rpm !== want.speed_rpm ||
                   rsp_data.zero_time_flag !== want.zero_time_flag) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("%0t: result %0d speed exp %0d got %0d, flag exp %0b got %0b",
                              $realtime, speeds_checked, want.speed_rpm,
                              rsp_data.speed_rpm, want.zero_time_flag,
                              rsp_data.zero_time_flag);
               end
               if (want.zero_time_flag)
                  zero_time_seen++;
               else if (want.speed_rpm == wtr_pkg::RPM_MAX)
                  clipped_seen++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm_tail && idle_on && $urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // idling comes and goes in stretches; also the run watchdog
   always @(posedge clock) begin : run_watch
      cycle_count++;
      if (phase_left == 0) begin
         idle_on <= !idle_on;
         phase_left = $urandom_range(20, 80);
      end else begin
         phase_left--;
      end
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles: %0d readings queued, %0d speeds outstanding",
                  cycle_count, pending_readings.size(), expected_speeds.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      logic [wtr_pkg::TIME_W-1:0]  stamp;
      logic [wtr_pkg::COUNT_W-1:0] pulses;
      int unsigned                 tick_span;
      int unsigned                 pulse_span;
      int unsigned                 run_len;
      int                          directed_total;
      foreach (window_time[i]) begin
         window_time[i]  = '0;
         window_count[i] = '0;
      end

      queue_reading('0, '0);                  // cleared entry, zero elapsed
      queue_reading('1, '1);                  // all-ones count acts like zero
      queue_reading(32'd1000, 15'd100);       // quotient over range
      // time and count wrap within this run
      for (int k = 0; k < 12; k++)
         queue_reading(32'hFFFF_0000 + 32'(k) * 32'd60000, 15'(32720 + 47 * k));
      // full ring with one stamp: zero elapsed after fill
      for (int k = 0; k < 8; k++)
         queue_reading(32'h1234_5678, 15'(k * 300));
      directed_total = pending_readings.size();

      // mostly steady fan runs with random rate; some raw noise
      while (pending_readings.size() < directed_total + RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 6))
               queue_reading($urandom, 15'($urandom));
         end else begin
            stamp  = $urandom;
            pulses = 15'($urandom);
            case ($urandom_range(0, 4))
               0: tick_span = 0;
               1: tick_span = 60;
               2: tick_span = 8000;
               3: tick_span = 200_000;
               default: tick_span = 32'h00FF_FFFF;
            endcase
            case ($urandom_range(0, 3))
               0: pulse_span = 2;
               1: pulse_span = 30;
               2: pulse_span = 400;
               default: pulse_span = 32767;
            endcase
            run_len = $urandom_range(9, 40);
            repeat (run_len) begin
               stamp  += $urandom_range(tick_span / 2, tick_span);
               pulses += 15'($urandom_range(0, pulse_span));
               queue_reading(stamp, pulses);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_readings.size() > 0 || req_valid || expected_speeds.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fault_count += expected_speeds.size();

      $display("%0d readings sent (%0d directed), %0d speeds checked in %0d cycles",
               readings_sent, directed_total, speeds_checked, cycle_count);
      $display("zero-time results: %0d, clipped: %0d, divided: %0d, faults: %0d",
               zero_time_seen, clipped_seen,
               speeds_checked - zero_time_seen - clipped_seen, fault_count);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wtr_pkg.sv
hw/rtl/wtr_ring.sv
hw/rtl/wtr_datapath.sv
hw/rtl/wtr_control.sv
hw/rtl/windowed_tachometer_rpm_unit.sv
tb/sv/tb_windowed_tachometer_rpm_unit.sv
